/* rtl/mpc_pkg.sv */
// Shared constants and control types for the multiclass perceptron classifier.
package mpc_pkg;

    localparam int NUM_CLASSES_DEF  = 4;
    localparam int NUM_FEATURES_DEF = 8;

    localparam int FEAT_W   = 8;
    localparam int PC_W     = 32;
    localparam int SIG_W    = 64;
    localparam int WEIGHT_W = 32;
    localparam int ETA_W    = 16;
    localparam int LABEL_W  = 2;
    localparam int PRED_W   = 2;

    localparam logic [ETA_W-1:0] ETA_RESET = 16'd256;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_TRAIN    = 1'b1;

    // scoring pipeline tag, one per class issued
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mpc_tag_t;

    // weight update strobe to the lanes
    typedef struct packed {
        logic en;
        logic add;
    } mpc_upd_t;

endpackage

/* rtl/mpc_lane.sv */
// One lane: per-class weights of one feature, score product and saturating update.
module mpc_lane #(
    parameter int NUM_CLASSES = mpc_pkg::NUM_CLASSES_DEF,
    parameter int IN_W        = mpc_pkg::FEAT_W
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [IN_W-1:0]                           feat,
    input  logic [mpc_pkg::ETA_W-1:0]                 eta,
    input  logic [$clog2(NUM_CLASSES)-1:0]            cls,
    input  mpc_pkg::mpc_upd_t                         upd,
    output logic signed [IN_W+mpc_pkg::WEIGHT_W-1:0]  prod
);

    localparam int WW    = mpc_pkg::WEIGHT_W;
    localparam int DW    = IN_W + mpc_pkg::ETA_W;
    localparam int SUM_W = ((DW + 1 > WW + 1) ? DW + 1 : WW + 1) + 1;

    logic signed [WW-1:0]      w_reg [NUM_CLASSES];
    logic signed [WW-1:0]      w_rd;
    logic signed [IN_W+WW:0]   prod_full;
    logic signed [IN_W+WW-1:0] prod_reg;
    logic [DW-1:0]             delta_reg;
    logic signed [SUM_W-1:0]   wx;
    logic signed [SUM_W-1:0]   dx;
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-WW:0]         sum_hi;
    logic signed [WW-1:0]      w_next;

    assign w_rd      = w_reg[cls];
    assign prod_full = $signed({1'b0, feat}) * w_rd;
    assign prod      = prod_reg;

    always_comb begin
        wx     = SUM_W'(w_rd);
        dx     = SUM_W'($signed({1'b0, delta_reg}));
        sum    = upd.add ? (wx + dx) : (wx - dx);
        sum_hi = sum[SUM_W-1:WW-1];
        if ((&sum_hi) || !(|sum_hi)) begin
            w_next = sum[WW-1:0];
        end else if (sum[SUM_W-1]) begin
            w_next = {1'b1, {(WW-1){1'b0}}};
        end else begin
            w_next = {1'b0, {(WW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                w_reg[k] <= '0;
            end
        end else if (upd.en) begin
            w_reg[cls] <= w_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_full[IN_W+WW-1:0];
        delta_reg <= DW'(feat) * DW'(eta);
    end

endmodule

/* rtl/mpc_merge.sv */
// Merge stage: adds lane products into a class score and keeps the running best class.
module mpc_merge #(
    parameter int NUM_CLASSES  = mpc_pkg::NUM_CLASSES_DEF,
    parameter int NUM_FEATURES = mpc_pkg::NUM_FEATURES_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  mpc_pkg::mpc_tag_t                                     tag_in,
    input  logic signed [mpc_pkg::FEAT_W+mpc_pkg::WEIGHT_W-1:0]   fprod [NUM_FEATURES],
    input  logic signed [mpc_pkg::PC_W+mpc_pkg::WEIGHT_W-1:0]     pprod,
    output logic                                                  done,
    output logic [$clog2(NUM_CLASSES)-1:0]                        best_cls
);

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int FPROD_W = mpc_pkg::FEAT_W + mpc_pkg::WEIGHT_W;
    localparam int PPROD_W = mpc_pkg::PC_W + mpc_pkg::WEIGHT_W;
    localparam int FSUM_W  = FPROD_W + $clog2(NUM_FEATURES + 1);
    localparam int SCORE_W = ((PPROD_W > FSUM_W) ? PPROD_W : FSUM_W) + 2;

    mpc_pkg::mpc_tag_t           tag2_reg;
    logic signed [FSUM_W-1:0]    fsum;
    logic signed [FSUM_W-1:0]    fsum_reg;
    logic signed [PPROD_W-1:0]   pcp_reg;
    logic signed [SCORE_W-1:0]   score;
    logic signed [SCORE_W-1:0]   best_reg;
    logic [CLS_W-1:0]            best_cls_reg;
    logic [CLS_W-1:0]            cnt_reg;
    logic [CLS_W-1:0]            cur_cls;
    logic                        done_reg;
    logic                        take;

    always_comb begin
        fsum = '0;
        for (int i = 0; i < NUM_FEATURES; i++) begin
            fsum = fsum + FSUM_W'(fprod[i]);
        end
    end

    assign score    = SCORE_W'(fsum_reg) + SCORE_W'(pcp_reg);
    assign cur_cls  = tag2_reg.first ? '0 : cnt_reg;
    assign take     = tag2_reg.first || (score > best_reg);
    assign done     = done_reg;
    assign best_cls = best_cls_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag2_reg     <= '0;
            cnt_reg      <= '0;
            best_cls_reg <= '0;
            done_reg     <= 1'b0;
        end else begin
            tag2_reg <= tag_in;
            done_reg <= tag2_reg.valid && tag2_reg.last;
            if (tag2_reg.valid) begin
                cnt_reg <= cur_cls + 1'b1;
                if (take) begin
                    best_cls_reg <= cur_cls;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        fsum_reg <= fsum;
        pcp_reg  <= pprod;
        if (tag2_reg.valid && take) begin
            best_reg <= score;
        end
    end

endmodule

/* rtl/multiclass_perceptron_classifier_top.sv */
// Multiclass perceptron classifier: lanes per feature plus pc lane, merge and control.
// Classify scores every class and returns the best; train also updates the weights, first
// of the predicted class downwards on a mismatch, then of the label class upwards.
// A new request is taken only once the last result is loaded; classes are scored one per
// cycle through the lane multipliers, then the two-stage merge, then the weight update states.
// Reset (aresetn low, synchronous): all weights zero, learning rate 1.0, no result pending.
module multiclass_perceptron_classifier_top #(
    parameter int NUM_CLASSES  = mpc_pkg::NUM_CLASSES_DEF,
    parameter int NUM_FEATURES = mpc_pkg::NUM_FEATURES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [mpc_pkg::PC_W-1:0]      s_pc,
    input  logic [mpc_pkg::SIG_W-1:0]     s_signature,
    input  logic [mpc_pkg::LABEL_W-1:0]   s_label,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mpc_pkg::PRED_W-1:0]    m_predicted,
    output logic                          m_mismatch,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mpc_pkg::ETA_W-1:0]     cfg_data
);

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int FW      = mpc_pkg::FEAT_W;
    localparam int FPROD_W = FW + mpc_pkg::WEIGHT_W;
    localparam int PPROD_W = mpc_pkg::PC_W + mpc_pkg::WEIGHT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_SUB,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                         state_reg;
    logic                           cmd_reg;
    logic [mpc_pkg::LABEL_W-1:0]    label_reg;
    logic [mpc_pkg::PC_W-1:0]       pc_reg;
    logic [mpc_pkg::SIG_W-1:0]      sig_reg;
    logic [mpc_pkg::ETA_W-1:0]      eta_reg;
    logic                           iss_act_reg;
    logic [CLS_W-1:0]               iss_cnt_reg;
    mpc_pkg::mpc_tag_t              tag_issue;
    mpc_pkg::mpc_tag_t              tag1_reg;
    logic [CLS_W-1:0]               pred_reg;
    logic                           mis_reg;
    logic                           m_valid_reg;
    logic [mpc_pkg::PRED_W-1:0]     m_predicted_reg;
    logic                           m_mismatch_reg;

    logic [CLS_W-1:0]               lab_cls;
    logic [CLS_W-1:0]               lane_cls;
    mpc_pkg::mpc_upd_t              upd;
    logic signed [FPROD_W-1:0]      fprod [NUM_FEATURES];
    logic signed [PPROD_W-1:0]      pprod;
    logic                           merge_done;
    logic [CLS_W-1:0]               merge_cls;
    logic                           train;
    logic                           mism;
    logic                           out_load;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_predicted = m_predicted_reg;
    assign m_mismatch  = m_mismatch_reg;

    assign lab_cls  = CLS_W'(label_reg);
    assign train    = (cmd_reg == mpc_pkg::CMD_TRAIN) && (int'(label_reg) < NUM_CLASSES);
    assign mism     = train && (merge_cls != lab_cls);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        tag_issue.valid = iss_act_reg;
        tag_issue.first = (iss_cnt_reg == '0);
        tag_issue.last  = (iss_cnt_reg == CLS_W'(NUM_CLASSES - 1));
        upd.en          = (state_reg == ST_SUB) || (state_reg == ST_ADD);
        upd.add         = (state_reg == ST_ADD);
        unique case (state_reg)
            ST_SUB:  lane_cls = pred_reg;
            ST_ADD:  lane_cls = lab_cls;
            default: lane_cls = iss_cnt_reg;
        endcase
    end

    for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_lane
        mpc_lane #(
            .NUM_CLASSES (NUM_CLASSES),
            .IN_W        (FW)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .feat    (sig_reg[FW*i +: FW]),
            .eta     (eta_reg),
            .cls     (lane_cls),
            .upd     (upd),
            .prod    (fprod[i])
        );
    end

    mpc_lane #(
        .NUM_CLASSES (NUM_CLASSES),
        .IN_W        (mpc_pkg::PC_W)
    ) u_pc_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .feat    (pc_reg),
        .eta     (eta_reg),
        .cls     (lane_cls),
        .upd     (upd),
        .prod    (pprod)
    );

    mpc_merge #(
        .NUM_CLASSES  (NUM_CLASSES),
        .NUM_FEATURES (NUM_FEATURES)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_in   (tag1_reg),
        .fprod    (fprod),
        .pprod    (pprod),
        .done     (merge_done),
        .best_cls (merge_cls)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            eta_reg     <= mpc_pkg::ETA_RESET;
            iss_act_reg <= 1'b0;
            iss_cnt_reg <= '0;
            tag1_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            tag1_reg <= tag_issue;
            if (cfg_valid) begin
                eta_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (iss_act_reg) begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
                if (tag_issue.last) begin
                    iss_act_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg   <= ST_SCORE;
                        iss_act_reg <= 1'b1;
                        iss_cnt_reg <= '0;
                    end
                end
                ST_SCORE: begin
                    if (merge_done) begin
                        pred_reg <= merge_cls;
                        mis_reg  <= mism;
                        if (mism) begin
                            state_reg <= ST_SUB;
                        end else if (train) begin
                            state_reg <= ST_ADD;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SUB: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_predicted_reg <= mpc_pkg::PRED_W'(pred_reg);
                        m_mismatch_reg  <= mis_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            label_reg <= s_label;
            pc_reg    <= s_pc;
            sig_reg   <= s_signature;
        end
    end

endmodule

/* rtl/mpc_checker.sv */
// Port-level checks for the multiclass perceptron classifier, bound to the top level.
module mpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mpc_pkg::PRED_W-1:0]    m_predicted,
    input logic                          m_mismatch
);

    // after reset: idle, nothing pending
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not idle after reset");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // a result only shows up at the end of a busy period
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a request");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_predicted) && $stable(m_mismatch)))
        else $error("stalled result changed");

endmodule

bind multiclass_perceptron_classifier_top mpc_checker u_mpc_checker (.*);

/* tb/mpc_result_checker.sv */
// Checker for the perceptron classifier: predicts each result from the accepted requests.
module mpc_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [mpc_pkg::PC_W-1:0]      s_pc,
    input  logic [mpc_pkg::SIG_W-1:0]     s_signature,
    input  logic [mpc_pkg::LABEL_W-1:0]   s_label,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mpc_pkg::PRED_W-1:0]    m_predicted,
    input  logic                          m_mismatch,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mpc_pkg::ETA_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int NUM_CLASSES  = mpc_pkg::NUM_CLASSES_DEF;
    localparam int NUM_FEATURES = mpc_pkg::NUM_FEATURES_DEF;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [mpc_pkg::PRED_W-1:0] predicted;
        logic                       mismatch;
    } verdict_t;

    verdict_t verdicts_q[$];
    logic signed [mpc_pkg::WEIGHT_W-1:0] feat_w [NUM_CLASSES][NUM_FEATURES];
    logic signed [mpc_pkg::WEIGHT_W-1:0] pc_w [NUM_CLASSES];
    logic [mpc_pkg::ETA_W-1:0] eta;
    int errors = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic signed [31:0] sat_step(input logic signed [31:0] w,
                                                    input logic [47:0] amount,
                                                    input logic add);
        logic signed [63:0] v;
        v = w;
        if (add) begin
            v = v + $signed({16'd0, amount});
        end else begin
            v = v - $signed({16'd0, amount});
        end
        if (v > SAT_HI) begin
            return SAT_HI[31:0];
        end
        if (v < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return v[31:0];
    endfunction

    // highest exact score, lowest index on ties
    function automatic logic [mpc_pkg::PRED_W-1:0] best_class(input logic [31:0] pc,
                                                              input logic [63:0] sig);
        logic signed [127:0] top_score;
        logic signed [127:0] score;
        logic signed [127:0] f;
        logic signed [127:0] w;
        int winner;
        top_score = '0;
        winner = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            score = '0;
            for (int i = 0; i < NUM_FEATURES; i++) begin
                f = $signed({1'b0, sig[8*i +: 8]});
                w = feat_w[c][i];
                score = score + f * w;
            end
            f = $signed({1'b0, pc});
            w = pc_w[c];
            score = score + f * w;
            if (c == 0 || score > top_score) begin
                top_score = score;
                winner = c;
            end
        end
        return winner[mpc_pkg::PRED_W-1:0];
    endfunction

    task automatic nudge_class(input int cls, input logic [31:0] pc, input logic [63:0] sig,
                               input logic add);
        logic [47:0] amount;
        for (int i = 0; i < NUM_FEATURES; i++) begin
            amount = {40'd0, sig[8*i +: 8]} * {32'd0, eta};
            feat_w[cls][i] = sat_step(feat_w[cls][i], amount, add);
        end
        amount = {16'd0, pc} * {32'd0, eta};
        pc_w[cls] = sat_step(pc_w[cls], amount, add);
    endtask

    always @(posedge aclk) begin : watch
        verdict_t want;
        logic [mpc_pkg::PRED_W-1:0] pred;
        logic miss;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                for (int i = 0; i < NUM_FEATURES; i++) begin
                    feat_w[c][i] = '0;
                end
                pc_w[c] = '0;
            end
            eta = mpc_pkg::ETA_RESET;
            verdicts_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                eta = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (verdicts_q.size() == 0) begin
                    $error("result with no request outstanding: predicted %0d mismatch %0d",
                           m_predicted, m_mismatch);
                    errors++;
                end else begin
                    want = verdicts_q.pop_front();
                    if (m_predicted !== want.predicted) begin
                        $error("predicted: expected %0d, got %0d", want.predicted, m_predicted);
                        errors++;
                    end
                    if (m_mismatch !== want.mismatch) begin
                        $error("mismatch: expected %0d, got %0d", want.mismatch, m_mismatch);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred = best_class(s_pc, s_signature);
                miss = 1'b0;
                if (s_cmd == mpc_pkg::CMD_TRAIN && int'(s_label) < NUM_CLASSES) begin
                    if (pred != s_label) begin
                        miss = 1'b1;
                        nudge_class(int'(pred), s_pc, s_signature, 1'b0);
                    end
                    nudge_class(int'(s_label), s_pc, s_signature, 1'b1);
                end
                want.predicted = pred;
                want.mismatch  = miss;
                verdicts_q = {verdicts_q, want};
            end
        end
        pending    <= verdicts_q.size();
        fail_count <= errors;
    end

endmodule

/* tb/tb_multiclass_perceptron_classifier_top.sv */
// Testbench top for the perceptron classifier: clock, reset, stimulus and verdict.
module tb_multiclass_perceptron_classifier_top;

    localparam int DRAIN = 2 * (mpc_pkg::NUM_CLASSES_DEF + 7);

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_cmd;
    logic [mpc_pkg::PC_W-1:0]      s_pc;
    logic [mpc_pkg::SIG_W-1:0]     s_signature;
    logic [mpc_pkg::LABEL_W-1:0]   s_label;
    logic                          m_valid;
    logic                          m_ready;
    logic [mpc_pkg::PRED_W-1:0]    m_predicted;
    logic                          m_mismatch;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mpc_pkg::ETA_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;
    int                            accepted_cnt = 0;
    int                            burst_left = 0;

    multiclass_perceptron_classifier_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pc        (s_pc),
        .s_signature (s_signature),
        .s_label     (s_label),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_predicted (m_predicted),
        .m_mismatch  (m_mismatch),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    mpc_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_pc        (s_pc),
        .s_signature (s_signature),
        .s_label     (s_label),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_predicted (m_predicted),
        .m_mismatch  (m_mismatch),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one request, with a random gap whenever a burst runs out
    task automatic offer(input logic cmd, input logic [31:0] pc, input logic [63:0] sig,
                         input logic [1:0] label);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     = 1'b1;
        s_cmd       = cmd;
        s_pc        = pc;
        s_signature = sig;
        s_label     = label;
        do @(posedge aclk); while (!s_ready);
        accepted_cnt++;
    endtask

    task automatic drain_requests();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = rate;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // receiver: stall patterns plus two long hold-offs to back up the pipeline
    initial begin : receiver
        int mode;
        int len;
        int cnt;
        bit held_early;
        bit held_late;
        m_ready = 1'b0;
        held_early = 1'b0;
        held_late = 1'b0;
        cnt = 0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if ((!held_early && accepted_cnt >= 200) || (!held_late && accepted_cnt >= 700)) begin
                if (accepted_cnt >= 700) begin
                    held_late = 1'b1;
                end
                held_early = 1'b1;
                repeat (300) begin
                    @(negedge aclk);
                    m_ready = 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 64);
            repeat (len) begin
                @(negedge aclk);
                cnt++;
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = $urandom_range(0, 1);
                    2: m_ready = ($urandom_range(0, 5) == 0);
                    default: m_ready = cnt[0];
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [15:0] rate_plan [8];
        logic [31:0] pc_v;
        logic [63:0] sig_v;
        logic [1:0]  lab_v;
        logic        cmd_v;
        int          kind;
        s_valid     = 1'b0;
        s_cmd       = mpc_pkg::CMD_CLASSIFY;
        s_pc        = '0;
        s_signature = '0;
        s_label     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        aresetn     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_rate(16'd256);
        offer(mpc_pkg::CMD_CLASSIFY, 32'h0, 64'h0, 2'd0);
        offer(mpc_pkg::CMD_CLASSIFY, 32'hFFFFFFFF, '1, 2'd3);
        offer(mpc_pkg::CMD_TRAIN, 32'h0, '1, 2'd3);
        offer(mpc_pkg::CMD_TRAIN, 32'h0, '1, 2'd3);
        offer(mpc_pkg::CMD_CLASSIFY, 32'h0, 64'h0101010101010101, 2'd0);
        offer(mpc_pkg::CMD_TRAIN, 32'hFFFFFFFF, 64'h0, 2'd1);
        offer(mpc_pkg::CMD_CLASSIFY, 32'h1, 64'h0, 2'd0);
        offer(mpc_pkg::CMD_TRAIN, 32'h1, 64'h00000000000000FF, 2'd2);
        offer(mpc_pkg::CMD_TRAIN, 32'h80000000, 64'hFF00000000000000, 2'd2);
        offer(mpc_pkg::CMD_TRAIN, 32'h0, 64'h8040201008040201, 2'd0);
        offer(mpc_pkg::CMD_CLASSIFY, 32'h7FFFFFFF, 64'h7F7F7F7F7F7F7F7F, 2'd1);
        offer(mpc_pkg::CMD_TRAIN, 32'h12345678, 64'hFEDCBA9876543210, 2'd1);
        drain_requests();

        // largest step: weights hit both saturation rails
        write_rate(16'hFFFF);
        offer(mpc_pkg::CMD_TRAIN, 32'hFFFFFFFF, '1, 2'd2);
        offer(mpc_pkg::CMD_TRAIN, 32'hFFFFFFFF, '1, 2'd3);
        offer(mpc_pkg::CMD_CLASSIFY, 32'hFFFFFFFF, '1, 2'd0);
        offer(mpc_pkg::CMD_TRAIN, 32'h0, '1, 2'd0);
        drain_requests();

        // zero step: mismatches reported, weights untouched
        write_rate(16'd0);
        offer(mpc_pkg::CMD_TRAIN, 32'hFFFFFFFF, '1, 2'd1);
        offer(mpc_pkg::CMD_CLASSIFY, 32'hFFFFFFFF, '1, 2'd1);
        offer(mpc_pkg::CMD_TRAIN, 32'h0, 64'h0, 2'd0);
        drain_requests();

        rate_plan = '{16'd256, 16'd1, 16'd16, 16'hFFFF, 16'd0, 16'd4096, 16'd0, 16'd256};
        rate_plan[6] = $urandom_range(0, 65535);
        for (int ph = 0; ph < 8; ph++) begin
            write_rate(rate_plan[ph]);
            repeat (116) begin
                kind = $urandom_range(0, 99);
                case ($urandom_range(0, 4))
                    0: pc_v = 32'h0;
                    1: pc_v = $urandom_range(0, 255);
                    2: pc_v = $urandom;
                    3: pc_v = 32'hFFFFFFFF;
                    default: pc_v = $urandom_range(0, 4095);
                endcase
                case ($urandom_range(0, 4))
                    0: sig_v = {$urandom, $urandom};
                    1: sig_v = 64'h0;
                    2: sig_v = '1;
                    3: sig_v = 64'hFF << (8 * $urandom_range(0, 7));
                    default: sig_v = {$urandom, $urandom} & 64'h0F0F0F0F0F0F0F0F;
                endcase
                // a learnable rule for part of the training, random labels for the rest
                lab_v = (kind < 40) ? sig_v[7:6] : 2'($urandom_range(0, 3));
                cmd_v = (kind < 70) ? mpc_pkg::CMD_TRAIN : mpc_pkg::CMD_CLASSIFY;
                offer(cmd_v, pc_v, sig_v, lab_v);
            end
            drain_requests();
        end

        repeat (DRAIN) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mpc_pkg.sv
rtl/mpc_lane.sv
rtl/mpc_merge.sv
rtl/multiclass_perceptron_classifier_top.sv
rtl/mpc_checker.sv
tb/mpc_result_checker.sv
tb/tb_multiclass_perceptron_classifier_top.sv
